@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL; empty when synthesized.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DPSD_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: property violated");
`define DPSD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define DPSD_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define DPSD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ hdl/dpsd_pkg.sv @@
// Types and constants of the page-split descriptor generator.
`default_nettype none
package dpsd_pkg;

  localparam int ADDR_W          = 64;
  localparam int LEN_W           = 25;
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 12;
  localparam int STAT_W          = 2;
  localparam int USED_W          = 4;
  localparam int ADDR_HIGH_SHIFT = 32;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_ADDR_WIDE  = 2'd1,
    ST_FRAGMENTED = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  // One buffer request as it travels through the queue.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              zero_len;
  } cmd_t;

  typedef struct packed {
    logic              entry_valid;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_address;
    logic [CNT_W-1:0]  entry_count_minus_one;
    logic              interrupt_on_done;
    status_t           status;
    logic [USED_W-1:0] entries_used;
    logic              last;
  } result_t;

  // Queue handshake toward the sequencer.
  typedef struct packed {
    logic head_valid;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

@@ hdl/dpsd_front.sv @@
// Front stage: accept a buffer beat, classify it and hand it to the queue.
`default_nettype none
module dpsd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dpsd_pkg::ADDR_W-1:0] in_buffer_address,
  input  wire logic [dpsd_pkg::LEN_W-1:0]  in_byte_length,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output dpsd_pkg::cmd_t                   push_cmd
);

  logic           vld_r;
  logic           vld_nxt;
  dpsd_pkg::cmd_t cmd_r;
  logic           take;

  assign in_ready   = !vld_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = vld_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.addr     <= in_buffer_address;
      cmd_r.len      <= in_byte_length;
      cmd_r.zero_len <= (in_byte_length == '0);
    end
  end

endmodule
`default_nettype wire

@@ hdl/dpsd_cmd_fifo.sv @@
// Two-entry command queue between the front stage and the sequencer.
`default_nettype none
module dpsd_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dpsd_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output dpsd_pkg::cmd_t      head_cmd,
  output dpsd_pkg::fifo_stat_t stat
);

  localparam int DEPTH = 2;

  dpsd_pkg::cmd_t mem_r [DEPTH];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           do_push;
  logic           do_pop;

  assign stat.full       = (count_r == 2'(DEPTH));
  assign stat.head_valid = (count_r != 2'd0);
  assign head_cmd        = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && stat.head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dpsd_back.sv @@
// Sequencer: cut a buffer into page descriptors, one per unstalled cycle.
`default_nettype none
module dpsd_back #(
  parameter int PAGE_BYTES    = 4096,
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wide_addressing,
  input  wire dpsd_pkg::cmd_t       head_cmd,
  input  wire dpsd_pkg::fifo_stat_t fifo_stat,
  output logic                      pop,
  output logic                      out_vld,
  input  wire logic                 out_rdy,
  output dpsd_pkg::result_t         out_res
);

  localparam int PB  = $clog2(PAGE_BYTES);
  localparam int N_W = $clog2(TABLE_ENTRIES + 1);

  dpsd_pkg::bk_state_t state_r;
  dpsd_pkg::bk_state_t state_nxt;

  logic [dpsd_pkg::ADDR_W-1:0] addr_r;
  logic [dpsd_pkg::LEN_W-1:0]  rem_r;
  logic                        zero_r;
  logic [N_W-1:0]              n_r;
  dpsd_pkg::result_t           res_r;
  logic                        res_vld_r;
  logic                        res_vld_nxt;

  logic                        slot_free;
  logic                        load;
  logic                        emit;
  logic [PB:0]                 room;
  logic [dpsd_pkg::LEN_W-1:0]  room_ext;
  logic [dpsd_pkg::LEN_W-1:0]  chunk;
  logic [dpsd_pkg::LEN_W-1:0]  chunk_m1;
  logic                        final_chunk;
  logic                        too_wide;
  logic [N_W-1:0]              n_inc;
  logic                        table_full;
  dpsd_pkg::result_t           res;

  assign slot_free = !res_vld_r || out_rdy;
  assign out_vld   = res_vld_r;
  assign out_res   = res_r;

  // Chunk runs to the end of the current page or the end of the buffer.
  assign room        = (PB+1)'(PAGE_BYTES) - {1'b0, addr_r[PB-1:0]};
  assign room_ext    = dpsd_pkg::LEN_W'(room);
  assign final_chunk = (rem_r <= room_ext);
  assign chunk       = final_chunk ? rem_r : room_ext;
  assign chunk_m1    = chunk - dpsd_pkg::LEN_W'(1);
  assign too_wide    = !wide_addressing &&
                       (addr_r[dpsd_pkg::ADDR_W-1:dpsd_pkg::ADDR_HIGH_SHIFT] != '0);
  assign n_inc       = n_r + N_W'(1);
  assign table_full  = (n_inc == N_W'(TABLE_ENTRIES));

  always_comb begin
    res = '0;
    if (zero_r) begin
      res.last = 1'b1;
    end else if (too_wide) begin
      res.entry_index   = dpsd_pkg::IDX_W'(n_r);
      res.entry_address = addr_r;
      res.status        = dpsd_pkg::ST_ADDR_WIDE;
      res.entries_used  = dpsd_pkg::USED_W'(n_r);
      res.last          = 1'b1;
    end else begin
      res.entry_valid           = 1'b1;
      res.entry_index           = dpsd_pkg::IDX_W'(n_r);
      res.entry_address         = addr_r;
      res.entry_count_minus_one = chunk_m1[dpsd_pkg::CNT_W-1:0];
      res.interrupt_on_done     = final_chunk;
      res.status                = (!final_chunk && table_full) ?
                                  dpsd_pkg::ST_FRAGMENTED : dpsd_pkg::ST_OK;
      res.entries_used          = dpsd_pkg::USED_W'(n_inc);
      res.last                  = final_chunk || table_full;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpsd_pkg::BK_IDLE: begin
        if (fifo_stat.head_valid) begin
          state_nxt = dpsd_pkg::BK_RUN;
        end
      end
      dpsd_pkg::BK_RUN: begin
        if (slot_free && res.last) begin
          state_nxt = dpsd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dpsd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    unique case (state_r)
      dpsd_pkg::BK_IDLE: load = fifo_stat.head_valid;
      dpsd_pkg::BK_RUN:  emit = slot_free;
      default: begin
        load = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign pop = load;

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (emit) begin
      res_vld_nxt = 1'b1;
    end else if (out_rdy) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dpsd_pkg::BK_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Advance the walk after every emitted descriptor.
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= head_cmd.addr;
      rem_r  <= head_cmd.len;
      zero_r <= head_cmd.zero_len;
      n_r    <= '0;
    end else if (emit) begin
      addr_r <= addr_r + dpsd_pkg::ADDR_W'(chunk);
      rem_r  <= rem_r - chunk;
      n_r    <= n_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dma_page_split_descriptor_gen_unit.sv @@
// Top level of the page-split scatter-gather descriptor generator.
// Path of a beat: front-stage register, queue, sequencer load, output register.
// The sequencer loads each buffer, then gives one descriptor per cycle while
// out_ready does not stall it, with at most TABLE_ENTRIES results per buffer.
// The front stage and a two-entry queue take further buffers while one is walked.
// Reset clears wide addressing to 0 and empties the front stage, queue and sequencer.
`default_nettype none
`include "assert_macros.svh"
module dma_page_split_descriptor_gen_unit #(
  parameter int PAGE_BYTES    = 4096,
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_wide_addressing,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dpsd_pkg::ADDR_W-1:0] in_buffer_address,
  input  wire logic [dpsd_pkg::LEN_W-1:0]  in_byte_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_entry_valid,
  output logic [dpsd_pkg::IDX_W-1:0]       out_entry_index,
  output logic [dpsd_pkg::ADDR_W-1:0]      out_entry_address,
  output logic [dpsd_pkg::CNT_W-1:0]       out_entry_count_minus_one,
  output logic                             out_interrupt_on_done,
  output logic [dpsd_pkg::STAT_W-1:0]      out_status,
  output logic [dpsd_pkg::USED_W-1:0]      out_entries_used,
  output logic                             out_last
);

  logic                 wide_r;
  logic                 wide_nxt;
  logic                 push_valid;
  dpsd_pkg::cmd_t       push_cmd;
  dpsd_pkg::cmd_t       head_cmd;
  dpsd_pkg::fifo_stat_t fifo_stat;
  logic                 pop;
  dpsd_pkg::result_t    res;

  assign cfg_ready = 1'b1;
  assign wide_nxt  = (cfg_valid && cfg_ready) ? cfg_wide_addressing : wide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else begin
      wide_r <= wide_nxt;
    end
  end

  dpsd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_buffer_address (in_buffer_address),
    .in_byte_length    (in_byte_length),
    .push_valid        (push_valid),
    .push_ready        (!fifo_stat.full),
    .push_cmd          (push_cmd)
  );

  dpsd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  dpsd_back #(
    .PAGE_BYTES    (PAGE_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .wide_addressing (wide_r),
    .head_cmd        (head_cmd),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .out_vld         (out_valid),
    .out_rdy         (out_ready),
    .out_res         (res)
  );

  assign out_entry_valid           = res.entry_valid;
  assign out_entry_index           = res.entry_index;
  assign out_entry_address         = res.entry_address;
  assign out_entry_count_minus_one = res.entry_count_minus_one;
  assign out_interrupt_on_done     = res.interrupt_on_done;
  assign out_status                = res.status;
  assign out_entries_used          = res.entries_used;
  assign out_last                  = res.last;

  `DPSD_ASSERT_ALWAYS(a_mid_is_clean, clk, rst_n, (out_valid && !out_last) |-> (out_entry_valid && out_status == dpsd_pkg::ST_OK))
  `DPSD_ASSERT_ALWAYS(a_err_ends_run, clk, rst_n, (out_valid && out_status != dpsd_pkg::ST_OK) |-> out_last)
  `DPSD_ASSERT_NEVER(a_irq_only_final, clk, rst_n, out_valid && out_interrupt_on_done && !(out_last && out_entry_valid && out_status == dpsd_pkg::ST_OK))

endmodule
`default_nettype wire
